// ===== rtl/ntps_pkg.sv =====
`default_nettype none

package ntps_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int IDX_W           = 6;
	localparam int COORD_W         = 16;
	localparam int DIFF_W          = COORD_W + 1;
	localparam int DIST_W          = 33;
	localparam int RANK_SLOTS      = 3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// One table entry as it leaves the position memory.
	typedef struct packed {
		logic                      valid;
		logic [IDX_W-1:0]          index;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] z;
	} scan_word_t;

	// One entry with its squared distance to the query point.
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  index;
		logic [DIST_W-1:0] dsq;
	} dist_word_t;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  index;
		logic [DIST_W-1:0] dsq;
	} rank_slot_t;

endpackage

`default_nettype wire

// ===== rtl/ntps_dist.sv =====
`default_nettype none

module ntps_dist (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ntps_pkg::scan_word_t               scan_s1,
	input  wire logic signed [ntps_pkg::COORD_W-1:0] qry_x,
	input  wire logic signed [ntps_pkg::COORD_W-1:0] qry_z,
	output ntps_pkg::dist_word_t                    dist_s4,
	output logic                                    busy
);
	import ntps_pkg::*;

	logic                     v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]         idx_s2, idx_s3, idx_s4;
	logic signed [DIFF_W-1:0] dx_s2, dz_s2;
	logic signed [2*DIFF_W-1:0] sqx, sqz;
	logic [DIST_W-1:0]        px_s3, pz_s3;
	logic [DIST_W-1:0]        sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= scan_s1.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// full-width signed squares; the magnitude always fits in DIST_W bits
	always_comb begin
		sqx = dx_s2 * dx_s2;
		sqz = dz_s2 * dz_s2;
	end

	// difference, then squares, then the sum: one register after each step
	always_ff @(posedge clk) begin
		idx_s2 <= scan_s1.index;
		dx_s2  <= DIFF_W'(qry_x) - DIFF_W'(scan_s1.x);
		dz_s2  <= DIFF_W'(qry_z) - DIFF_W'(scan_s1.z);
		idx_s3 <= idx_s2;
		px_s3  <= sqx[DIST_W-1:0];
		pz_s3  <= sqz[DIST_W-1:0];
		idx_s4 <= idx_s3;
		sum_s4 <= px_s3 + pz_s3;
	end

	assign dist_s4.valid = v_s4;
	assign dist_s4.index = idx_s4;
	assign dist_s4.dsq   = sum_s4;
	assign busy          = v_s2 | v_s3 | v_s4;

endmodule

`default_nettype wire

// ===== rtl/ntps_rank.sv =====
`default_nettype none

module ntps_rank (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       clear,
	input  wire ntps_pkg::dist_word_t                       dist_s4,
	output ntps_pkg::rank_slot_t [ntps_pkg::RANK_SLOTS-1:0] slots
);
	import ntps_pkg::*;

	rank_slot_t [RANK_SLOTS-1:0] slot_q;
	rank_slot_t                  cand;
	logic                        hit0, hit1, hit2;

	always_comb begin
		cand.valid = 1'b1;
		cand.index = dist_s4.index;
		cand.dsq   = dist_s4.dsq;
		// ties go to the later entry
		hit0 = !slot_q[0].valid || (dist_s4.dsq <= slot_q[0].dsq);
		hit1 = !slot_q[1].valid || (dist_s4.dsq <= slot_q[1].dsq);
		hit2 = !slot_q[2].valid || (dist_s4.dsq <= slot_q[2].dsq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (clear) begin
			slot_q <= '0;
		end else if (dist_s4.valid) begin
			if (hit0) begin
				slot_q[2] <= slot_q[1];
				slot_q[1] <= slot_q[0];
				slot_q[0] <= cand;
			end else if (hit1) begin
				slot_q[2] <= slot_q[1];
				slot_q[1] <= cand;
			end else if (hit2) begin
				slot_q[2] <= cand;
			end
		end
	end

	assign slots = slot_q;

	a_order_01: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q[1].valid |-> (slot_q[0].valid && slot_q[0].dsq <= slot_q[1].dsq))
		else $error("rank slots one and two out of order");
	a_order_12: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q[2].valid |-> (slot_q[1].valid && slot_q[1].dsq <= slot_q[2].dsq))
		else $error("rank slots two and three out of order");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (slot_q == '0))
		else $error("ranking not emptied on a new word");

endmodule

`default_nettype wire

// ===== rtl/nearest_three_point_select.sv =====
// Write word: taken in idle, it passes through the done state into the output register.
// Query word: ENTRIES = min(TABLE_DEPTH, 64) entries are scanned at one position read per cycle,
// set by the single read port, then the distance pipeline drains and the done state follows.
// One word is worked on at a time; the next is taken while a result waits at the output.
// Reset (asynchronous, active low) clears the present bits, the control state and the
// output valid; the position memory is not cleared and is read only behind a present bit.
`default_nettype none

module nearest_three_point_select #(
	parameter int TABLE_DEPTH = ntps_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                req_type,
	input  wire logic [ntps_pkg::IDX_W-1:0]          entry_index,
	input  wire logic signed [ntps_pkg::COORD_W-1:0] entry_x,
	input  wire logic signed [ntps_pkg::COORD_W-1:0] entry_z,
	input  wire logic                                entry_enable,
	input  wire logic signed [ntps_pkg::COORD_W-1:0] query_x,
	input  wire logic signed [ntps_pkg::COORD_W-1:0] query_z,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     first_valid,
	output logic [ntps_pkg::IDX_W-1:0]               first_index,
	output logic [ntps_pkg::DIST_W-1:0]              first_dist_sq,
	output logic                                     second_valid,
	output logic [ntps_pkg::IDX_W-1:0]               second_index,
	output logic [ntps_pkg::DIST_W-1:0]              second_dist_sq,
	output logic                                     third_valid,
	output logic [ntps_pkg::IDX_W-1:0]               third_index,
	output logic [ntps_pkg::DIST_W-1:0]              third_dist_sq
);
	import ntps_pkg::*;

	// Only 64 slots can ever be addressed by a write word, so deeper tables
	// would hold nothing beyond them: size the store to what is reachable.
	localparam int ENTRIES = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int POS_W   = 2 * COORD_W;

	state_t state_q, state_d;

	logic                      in_acc;
	logic                      wr_ok;
	logic                      mem_we;
	logic                      issue;
	logic                      load_out;
	logic                      scan_last;
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W-1:0]         addr_q;
	logic [ENTRIES-1:0]        present_q;
	logic signed [COORD_W-1:0] qry_x_q, qry_z_q;

	logic [POS_W-1:0]          pos_mem [ENTRIES];
	logic [POS_W-1:0]          rd_data_s1;
	logic                      rd_valid_s1;
	logic [ADDR_W-1:0]         rd_addr_s1;

	scan_word_t                  scan_s1;
	dist_word_t                  dist_s4;
	logic                        dist_busy;
	rank_slot_t [RANK_SLOTS-1:0] slots;

	logic                      out_valid_q;
	rank_slot_t [RANK_SLOTS-1:0] out_q;

	assign in_acc    = in_valid && !in_stall;
	assign wr_ok     = 32'(entry_index) < TABLE_DEPTH;
	assign wr_addr   = entry_index[ADDR_W-1:0];
	assign mem_we    = in_acc && (req_type == REQ_WRITE) && wr_ok;
	assign scan_last = (addr_q == ADDR_W'(ENTRIES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (req_type == REQ_QUERY) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// advance once the last entry has been ranked
				if (!rd_valid_s1 && !dist_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_SCAN:  issue    = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			present_q   <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// walk the table once per query, then drop back to the first entry
			if (issue) begin
				addr_q <= scan_last ? '0 : addr_q + 1'b1;
			end
			if (mem_we) begin
				present_q[wr_addr] <= entry_enable;
			end
			rd_valid_s1 <= issue && present_q[addr_q];
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			qry_x_q <= query_x;
			qry_z_q <= query_z;
		end
		if (load_out) begin
			out_q <= slots;
		end
		rd_addr_s1 <= addr_q;
	end

	// position store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pos_mem[wr_addr] <= {entry_x, entry_z};
		end
		rd_data_s1 <= pos_mem[addr_q];
	end

	always_comb begin
		scan_s1.valid = rd_valid_s1;
		scan_s1.index = IDX_W'(rd_addr_s1);
		scan_s1.x     = rd_data_s1[POS_W-1:COORD_W];
		scan_s1.z     = rd_data_s1[COORD_W-1:0];
	end

	ntps_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_s1 (scan_s1),
		.qry_x   (qry_x_q),
		.qry_z   (qry_z_q),
		.dist_s4 (dist_s4),
		.busy    (dist_busy)
	);

	// every accepted word starts from an empty ranking; a write word leaves it empty
	ntps_rank u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (in_acc),
		.dist_s4 (dist_s4),
		.slots   (slots)
	);

	assign out_valid      = out_valid_q;
	assign first_valid    = out_q[0].valid;
	assign first_index    = out_q[0].index;
	assign first_dist_sq  = out_q[0].dsq;
	assign second_valid   = out_q[1].valid;
	assign second_index   = out_q[1].index;
	assign second_dist_sq = out_q[1].dsq;
	assign third_valid    = out_q[2].valid;
	assign third_index    = out_q[2].index;
	assign third_dist_sq  = out_q[2].dsq;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_valid_s1 && !dist_busy))
		else $error("distance pipeline busy while idle");
	a_addr_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> (addr_q == '0))
		else $error("scan address not at first entry outside a scan");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word loaded outside the done state");

endmodule

`default_nettype wire

// ===== sim/ntps_monitor.sv =====
module ntps_monitor #(
	parameter int TABLE_DEPTH = ntps_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                req_type,
	input  logic [ntps_pkg::IDX_W-1:0]          entry_index,
	input  logic signed [ntps_pkg::COORD_W-1:0] entry_x,
	input  logic signed [ntps_pkg::COORD_W-1:0] entry_z,
	input  logic                                entry_enable,
	input  logic signed [ntps_pkg::COORD_W-1:0] query_x,
	input  logic signed [ntps_pkg::COORD_W-1:0] query_z,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                first_valid,
	input  logic [ntps_pkg::IDX_W-1:0]          first_index,
	input  logic [ntps_pkg::DIST_W-1:0]         first_dist_sq,
	input  logic                                second_valid,
	input  logic [ntps_pkg::IDX_W-1:0]          second_index,
	input  logic [ntps_pkg::DIST_W-1:0]         second_dist_sq,
	input  logic                                third_valid,
	input  logic [ntps_pkg::IDX_W-1:0]          third_index,
	input  logic [ntps_pkg::DIST_W-1:0]         third_dist_sq,
	output int                                  fails,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// one place of the ranking: occupied flag, entry index, squared distance
	typedef struct packed {
		logic                        hit;
		logic [ntps_pkg::IDX_W-1:0]  idx;
		logic [ntps_pkg::DIST_W-1:0] sq;
	} place_t;

	typedef struct packed {
		place_t first;
		place_t second;
		place_t third;
	} ranking_t;

	logic signed [ntps_pkg::COORD_W-1:0] point_x [TABLE_DEPTH];
	logic signed [ntps_pkg::COORD_W-1:0] point_z [TABLE_DEPTH];
	bit                                  point_present [TABLE_DEPTH];
	ranking_t                            rankings_due [$];

	initial fails = 0;

	// scan the present entries in index order; an equal distance lets the later entry in
	function automatic ranking_t rank_nearest(input logic signed [ntps_pkg::COORD_W-1:0] qx,
			input logic signed [ntps_pkg::COORD_W-1:0] qz);
		place_t   slot [3];
		place_t   cand;
		longint   dx;
		longint   dz;
		longint   sum;
		ranking_t r;
		for (int k = 0; k < 3; k++)
			slot[k] = '0;
		for (int e = 0; e < TABLE_DEPTH; e++) begin
			if (point_present[e]) begin
				dx = longint'(qx) - longint'(point_x[e]);
				dz = longint'(qz) - longint'(point_z[e]);
				sum = dx * dx + dz * dz;
				cand.hit = 1'b1;
				cand.idx = e[ntps_pkg::IDX_W-1:0];
				cand.sq = sum[ntps_pkg::DIST_W-1:0];
				if (!slot[0].hit || cand.sq <= slot[0].sq) begin
					slot[2] = slot[1];
					slot[1] = slot[0];
					slot[0] = cand;
				end else if (!slot[1].hit || cand.sq <= slot[1].sq) begin
					slot[2] = slot[1];
					slot[1] = cand;
				end else if (!slot[2].hit || cand.sq <= slot[2].sq) begin
					slot[2] = cand;
				end
			end
		end
		r.first = slot[0];
		r.second = slot[1];
		r.third = slot[2];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ranking_t want;
		if (!arst_n) begin
			for (int e = 0; e < TABLE_DEPTH; e++)
				point_present[e] = 1'b0;
			rankings_due.delete();
			pending <= 0;
		end else begin
			// retire the oldest word first: a result never leaves on the edge its word enters
			if (out_valid && !out_stall) begin
				if (rankings_due.size() == 0) begin
					$error("result word with nothing outstanding");
					fails++;
				end else begin
					want = rankings_due.pop_front();
					check_field("first_valid", want.first.hit, first_valid);
					check_field("first_index", want.first.idx, first_index);
					check_field("first_dist_sq", want.first.sq, first_dist_sq);
					check_field("second_valid", want.second.hit, second_valid);
					check_field("second_index", want.second.idx, second_index);
					check_field("second_dist_sq", want.second.sq, second_dist_sq);
					check_field("third_valid", want.third.hit, third_valid);
					check_field("third_index", want.third.idx, third_index);
					check_field("third_dist_sq", want.third.sq, third_dist_sq);
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type == ntps_pkg::REQ_WRITE) begin
					if (entry_index < TABLE_DEPTH) begin
						point_x[entry_index] = entry_x;
						point_z[entry_index] = entry_z;
						point_present[entry_index] = entry_enable;
					end
					rankings_due.push_back(ranking_t'('0));
				end else begin
					rankings_due.push_back(rank_nearest(query_x, query_z));
				end
			end
			pending <= rankings_due.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ntps_pkg::*;

	// The limit covers the slowest legal run: the query scans, the long receiver stalls
	// and sender gaps, plus one long hold.
	localparam int CYCLE_LIMIT  = 600000;
	// long enough for the output register, the word in work and the input to back up
	localparam int HOLD_CYCLES  = 400;
	// watch for stray results for longer than a query takes
	localparam int DRAIN_CYCLES = 100;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      in_valid     = 1'b0;
	logic                      req_type     = REQ_WRITE;
	logic [IDX_W-1:0]          entry_index  = '0;
	logic signed [COORD_W-1:0] entry_x      = '0;
	logic signed [COORD_W-1:0] entry_z      = '0;
	logic                      entry_enable = 1'b0;
	logic signed [COORD_W-1:0] query_x      = '0;
	logic signed [COORD_W-1:0] query_z      = '0;
	logic                      out_stall    = 1'b0;

	logic                      in_stall;
	logic                      out_valid;
	logic                      first_valid;
	logic [IDX_W-1:0]          first_index;
	logic [DIST_W-1:0]         first_dist_sq;
	logic                      second_valid;
	logic [IDX_W-1:0]          second_index;
	logic [DIST_W-1:0]         second_dist_sq;
	logic                      third_valid;
	logic [IDX_W-1:0]          third_index;
	logic [DIST_W-1:0]         third_dist_sq;

	int fails;
	int pending;
	int cycles   = 0;
	// calm: no sender gaps and no random receiver stalls
	bit calm     = 1'b0;
	// hold_req: ask the receiver for one long hold-off
	bit hold_req = 1'b0;

	always #6ns clk = ~clk;

	nearest_three_point_select u_top (.*);

	ntps_monitor u_monitor (.*);

	// Guard against a hung block: give up at the limit and call it a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver side. Decide the stall for the coming cycle at each falling edge:
	// mostly open, short bursts now and then, the odd long one, and one very long
	// hold-off on request while the sender keeps pushing words in.
	initial begin : result_stall
		int left;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				left = HOLD_CYCLES;
			end else if (left == 0 && !calm && $urandom_range(0, 7) == 0) begin
				left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
			end
			out_stall <= (left != 0);
			if (left != 0)
				left--;
		end
	end

	// Sender gap after a word: mostly back to back, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Coordinates: the two extremes, a tight cluster round the origin so that
	// equal distances turn up often, and the full range otherwise.
	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7fff;
			end
			2, 3: begin
				return 16'(int'($urandom_range(0, 8)) - 4);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Drive one word at the falling edge, hold it until it is taken, then maybe
	// drop valid for a gap. Valid stays up across back-to-back words.
	task automatic offer_word(input logic rt, input logic [IDX_W-1:0] idx,
			input logic signed [COORD_W-1:0] ex, input logic signed [COORD_W-1:0] ez,
			input logic en, input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qz);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rt;
		entry_index <= idx;
		entry_x <= ex;
		entry_z <= ez;
		entry_enable <= en;
		query_x <= qx;
		query_z <= qz;
		do
			@(posedge clk);
		while (in_stall);
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Store one table entry; the query fields carry noise.
	task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] z, input logic en);
		offer_word(REQ_WRITE, idx, x, z, en, 16'($urandom), 16'($urandom));
	endtask

	// Ask for the three nearest entries; the entry fields carry noise.
	task automatic ask_nearest(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qz);
		offer_word(REQ_QUERY, 6'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), qx, qz);
	endtask

	// Half writes, half queries; most writes mark the entry present, some clear it.
	task automatic random_word();
		if ($urandom_range(0, 1) == 0)
			write_entry(6'($urandom), pick_coord(), pick_coord(), $urandom_range(0, 4) != 0);
		else
			ask_nearest(pick_coord(), pick_coord());
	endtask

	// Drop valid and wait until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		// hold reset at the start and release it at a falling edge, away from the rising edge
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// empty table: all three places unoccupied
		ask_nearest(16'sd0, 16'sd0);
		// opposite corners: largest possible squared distance
		write_entry(6'd0, 16'sh8000, 16'sh8000, 1'b1);
		ask_nearest(16'sh7fff, 16'sh7fff);
		write_entry(6'd63, 16'sh7fff, 16'sh7fff, 1'b1);
		ask_nearest(16'sh8000, 16'sh8000);
		// absent entry is stored but skipped; only two places filled
		write_entry(6'd5, 16'sd0, 16'sd0, 1'b0);
		ask_nearest(16'sd0, 16'sd0);
		// four entries at the same distance: the later index takes each place
		write_entry(6'd10, 16'sd100, 16'sd0, 1'b1);
		write_entry(6'd11, -16'sd100, 16'sd0, 1'b1);
		write_entry(6'd12, 16'sd0, 16'sd100, 1'b1);
		write_entry(6'd13, 16'sd0, -16'sd100, 1'b1);
		ask_nearest(16'sd0, 16'sd0);
		// switch the stored entry on: query lands on it exactly
		write_entry(6'd5, 16'sd0, 16'sd0, 1'b1);
		ask_nearest(16'sd0, 16'sd0);
		// clear one of the tied entries again
		write_entry(6'd13, 16'sd0, -16'sd100, 1'b0);
		ask_nearest(16'sd0, 16'sd0);
		// mixed-sign corner, before and after an overwrite of entry 0
		ask_nearest(16'sh7fff, 16'sh8000);
		write_entry(6'd0, 16'sh7fff, 16'sh8000, 1'b1);
		ask_nearest(16'sh7fff, 16'sh8000);

		repeat (220) random_word();

		// hold the receiver off while words keep coming, so the block backs up
		calm = 1'b1;
		hold_req = 1'b1;
		repeat (30) random_word();
		calm = 1'b0;

		// pause the sender until everything is back
		drain_results();

		// a stretch with no idling on either side
		calm = 1'b1;
		repeat (100) random_word();
		calm = 1'b0;

		repeat (230) random_word();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== nearest_three_point_select.f =====
rtl/ntps_pkg.sv
rtl/ntps_dist.sv
rtl/ntps_rank.sv
rtl/nearest_three_point_select.sv
sim/ntps_monitor.sv
sim/testbench.sv
